// ----- sv/gbn_pkg.sv -----
// shared constants, codes and control structs of the go-back-n sender
package gbn_pkg;

   localparam int SEQ_SPACE = 8;
   localparam int SEQ_W = $clog2(SEQ_SPACE);
   localparam int PAYLOAD_W = 32;
   localparam int WIN_W = 3;
   localparam int CMP_W = ((WIN_W > SEQ_W) ? WIN_W : SEQ_W) + 1;
   localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(4);
   localparam logic [CMP_W-1:0] MAX_WIN = CMP_W'(SEQ_SPACE - 1);

   typedef enum logic [1:0] {
      ACT_SEND    = 2'd0,
      ACT_ACK     = 2'd1,
      ACT_TIMEOUT = 2'd2,
      ACT_NOP     = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      TMR_NONE    = 2'd0,
      TMR_START   = 2'd1,
      TMR_STOP    = 2'd2,
      TMR_RESTART = 2'd3
   } timer_type;

   typedef struct packed {
      logic load_single;
      logic start_replay;
      logic emit_replay;
   } dp_cmd_type;

   typedef struct packed {
      logic replay_needed;
      logic replay_last;
   } dp_status_type;

   typedef struct packed {
      logic                 packet_valid;
      logic [SEQ_W-1:0]     packet_seq;
      logic [PAYLOAD_W-1:0] packet_payload;
      logic                 send_accepted;
      logic                 window_full;
      logic [1:0]           timer_cmd;
      logic                 last;
   } rsp_data_type;

endpackage

// ----- sv/gbn_if.sv -----
// valid/ready channel interfaces for requests and responses
interface gbn_req_if;
   logic                          valid;
   logic                          ready;
   logic [1:0]                    action;
   logic [gbn_pkg::PAYLOAD_W-1:0] payload;
   logic [gbn_pkg::SEQ_W-1:0]     ack_number;
   logic                          ack_checksum_ok;

   modport source (output valid, action, payload, ack_number, ack_checksum_ok,
                   input ready);
   modport sink (input valid, action, payload, ack_number, ack_checksum_ok,
                 output ready);
endinterface

interface gbn_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          packet_valid;
   logic [gbn_pkg::SEQ_W-1:0]     packet_seq;
   logic [gbn_pkg::PAYLOAD_W-1:0] packet_payload;
   logic                          send_accepted;
   logic                          window_full;
   logic [1:0]                    timer_cmd;
   logic                          last;

   modport source (output valid, packet_valid, packet_seq, packet_payload,
                   send_accepted, window_full, timer_cmd, last,
                   input ready);
   modport sink (input valid, packet_valid, packet_seq, packet_payload,
                 send_accepted, window_full, timer_cmd, last,
                 output ready);
endinterface

// ----- sv/gbn_ram.sv -----
// generic simple dual-port ram with registered read
module gbn_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/gbn_datapath.sv -----
// window pointers, payload buffer, replay counter and response register
module gbn_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [gbn_pkg::WIN_W-1:0]     csr_wr_data,
   input  logic [1:0]                    action,
   input  logic [gbn_pkg::PAYLOAD_W-1:0] payload,
   input  logic [gbn_pkg::SEQ_W-1:0]     ack_number,
   input  logic                          ack_checksum_ok,
   input  gbn_pkg::dp_cmd_type           cmd,
   output gbn_pkg::dp_status_type        status,
   output gbn_pkg::rsp_data_type         rsp_data
);

   logic [gbn_pkg::WIN_W-1:0]   window_size_ff, window_size_in;
   logic [gbn_pkg::SEQ_W-1:0]   base_ff, base_in;
   logic [gbn_pkg::SEQ_W-1:0]   next_ff, next_in;
   logic [gbn_pkg::SEQ_W-1:0]   idx_ff, idx_in;
   logic [gbn_pkg::SEQ_W-1:0]   cnt_ff, cnt_in;
   logic                        full_snap_ff, full_snap_in;
   gbn_pkg::rsp_data_type       out_ff, out_in;

   logic [gbn_pkg::CMP_W-1:0]     win_raw, eff_win, outs_c, outs_ack_c;
   logic [gbn_pkg::SEQ_W-1:0]     outs, ack_dist, ack_base, outs_ack;
   logic                          can_send, ack_good;
   gbn_pkg::rsp_data_type         single, replay;
   logic                          ram_wr_en, ram_rd_en;
   logic [gbn_pkg::SEQ_W-1:0]     ram_rd_addr;
   logic [gbn_pkg::PAYLOAD_W-1:0] ram_rd_data;

   always_comb begin
      win_raw    = gbn_pkg::CMP_W'(window_size_ff);
      eff_win    = (win_raw > gbn_pkg::MAX_WIN) ? gbn_pkg::MAX_WIN : win_raw;
      outs       = next_ff - base_ff;
      outs_c     = gbn_pkg::CMP_W'(outs);
      can_send   = outs_c < eff_win;
      ack_dist   = ack_number - base_ff;
      ack_good   = ack_checksum_ok && (ack_dist < outs);
      ack_base   = ack_number + gbn_pkg::SEQ_W'(1);
      outs_ack   = next_ff - ack_base;
      outs_ack_c = gbn_pkg::CMP_W'(outs_ack);
   end

   // result of any item that yields exactly one response
   always_comb begin
      single = '0;
      single.last = 1'b1;
      single.window_full = outs_c >= eff_win;
      ram_wr_en = 1'b0;
      base_in = base_ff;
      next_in = next_ff;
      case (action)
         gbn_pkg::ACT_SEND: begin
            if (can_send) begin
               single.packet_valid   = 1'b1;
               single.packet_seq     = next_ff;
               single.packet_payload = payload;
               single.send_accepted  = 1'b1;
               single.window_full    = (outs_c + gbn_pkg::CMP_W'(1)) >= eff_win;
               single.timer_cmd      = (outs == '0) ? gbn_pkg::TMR_START
                                                    : gbn_pkg::TMR_NONE;
               ram_wr_en = cmd.load_single;
               if (cmd.load_single) begin
                  next_in = next_ff + gbn_pkg::SEQ_W'(1);
               end
            end else begin
               single.window_full = 1'b1;
            end
         end
         gbn_pkg::ACT_ACK: begin
            if (ack_good) begin
               single.window_full = outs_ack_c >= eff_win;
               single.timer_cmd   = (ack_base == next_ff) ? gbn_pkg::TMR_STOP
                                                          : gbn_pkg::TMR_RESTART;
               if (cmd.load_single) begin
                  base_in = ack_base;
               end
            end
         end
         gbn_pkg::ACT_TIMEOUT: begin
            // only reaches here with an empty window
            single.timer_cmd = gbn_pkg::TMR_RESTART;
         end
         default: begin
            single.timer_cmd = gbn_pkg::TMR_NONE;
         end
      endcase
   end

   // one replayed packet from the buffer
   always_comb begin
      replay = '0;
      replay.packet_valid   = 1'b1;
      replay.packet_seq     = base_ff + idx_ff;
      replay.packet_payload = ram_rd_data;
      replay.window_full    = full_snap_ff;
      replay.timer_cmd      = (idx_ff == '0) ? gbn_pkg::TMR_RESTART : gbn_pkg::TMR_NONE;
      replay.last           = status.replay_last;
   end

   always_comb begin
      status.replay_needed = (action == gbn_pkg::ACT_TIMEOUT) && (outs != '0);
      status.replay_last   = (idx_ff + gbn_pkg::SEQ_W'(1)) == cnt_ff;

      ram_rd_en   = cmd.start_replay || cmd.emit_replay;
      ram_rd_addr = cmd.start_replay ? base_ff
                                     : base_ff + idx_ff + gbn_pkg::SEQ_W'(1);

      window_size_in = csr_wr_en ? csr_wr_data : window_size_ff;
      idx_in       = idx_ff;
      cnt_in       = cnt_ff;
      full_snap_in = full_snap_ff;
      out_in       = out_ff;
      if (cmd.start_replay) begin
         idx_in       = '0;
         cnt_in       = outs;
         full_snap_in = outs_c >= eff_win;
      end
      if (cmd.emit_replay) begin
         idx_in = idx_ff + gbn_pkg::SEQ_W'(1);
         out_in = replay;
      end
      if (cmd.load_single) begin
         out_in = single;
      end
   end

   gbn_ram #(
      .WIDTH (gbn_pkg::PAYLOAD_W),
      .DEPTH (gbn_pkg::SEQ_SPACE)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (next_ff),
      .wr_data (payload),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         window_size_ff <= gbn_pkg::WINDOW_RESET;
         base_ff        <= '0;
         next_ff        <= '0;
         idx_ff         <= '0;
         cnt_ff         <= '0;
      end else begin
         window_size_ff <= window_size_in;
         base_ff        <= base_in;
         next_ff        <= next_in;
         idx_ff         <= idx_in;
         cnt_ff         <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      full_snap_ff <= full_snap_in;
      out_ff       <= out_in;
   end

   assign rsp_data = out_ff;

endmodule

// ----- sv/gbn_ctrl.sv -----
// sequencer: single-result items and timeout replay bursts
module gbn_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  gbn_pkg::dp_status_type status,
   output gbn_pkg::dp_cmd_type    cmd
);

   typedef enum logic [1:0] {
      ST_IDLE   = 2'b01,
      ST_REPLAY = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic      out_valid_ff, out_valid_in;
   logic      out_free;

   always_comb begin
      out_free     = !out_valid_ff || rsp_ready;
      state_in     = state_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = out_free;
            if (req_valid && out_free) begin
               if (status.replay_needed) begin
                  cmd.start_replay = 1'b1;
                  state_in = ST_REPLAY;
               end else begin
                  cmd.load_single = 1'b1;
                  out_valid_in = 1'b1;
               end
            end
         end
         ST_REPLAY: begin
            if (out_free) begin
               cmd.emit_replay = 1'b1;
               out_valid_in = 1'b1;
               if (status.replay_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_valid = out_valid_ff;

endmodule

// ----- sv/go_back_n_window_sender.sv -----
// top level of the go-back-n sender: controller, datapath and checks
//
// channel  | direction | handshake        | carries
// req_if   | in        | valid / ready    | action, payload, ack_number, ack_checksum_ok
// rsp_if   | out       | valid / ready    | packet fields, send_accepted, window_full,
//          |           |                  | timer_cmd, last
// csr_*    | in        | csr_wr_en only   | window_size (3 bits)
//
// send, ack, no-op and empty-window timeout transactions yield one response each;
// a new one is taken every cycle as long as the response register is free or
// being drained
// a timeout with packets outstanding holds off requests while it replays
// them: the accepting cycle starts the buffer read, then one packet per cycle
// while the response register is free or being drained, set by the single read port
// of the payload buffer; reset is synchronous; it clears pointers, sets window_size
// to 4 and drops rsp valid; the payload buffer is not cleared
// a stalled response holds its register and blocks further requests
module go_back_n_window_sender (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic [gbn_pkg::WIN_W-1:0] csr_wr_data,
   gbn_req_if.sink                   req_if,
   gbn_rsp_if.source                 rsp_if
);

   gbn_pkg::dp_cmd_type    cmd;
   gbn_pkg::dp_status_type status;
   gbn_pkg::rsp_data_type  rsp_data;
   logic                   req_accept;

   // sequencer owns the handshakes
   gbn_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // pointers, buffer and response register
   gbn_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .action          (req_if.action),
      .payload         (req_if.payload),
      .ack_number      (req_if.ack_number),
      .ack_checksum_ok (req_if.ack_checksum_ok),
      .cmd             (cmd),
      .status          (status),
      .rsp_data        (rsp_data)
   );

   // response fields straight from the output register
   assign rsp_if.packet_valid   = rsp_data.packet_valid;
   assign rsp_if.packet_seq     = rsp_data.packet_seq;
   assign rsp_if.packet_payload = rsp_data.packet_payload;
   assign rsp_if.send_accepted  = rsp_data.send_accepted;
   assign rsp_if.window_full    = rsp_data.window_full;
   assign rsp_if.timer_cmd      = rsp_data.timer_cmd;
   assign rsp_if.last           = rsp_data.last;

   assign req_accept = req_if.valid && req_if.ready;

   // a replay burst must lock out requests in the next cycle
   a_replay_blocks: assert property (@(posedge clock) disable iff (reset)
      (req_accept && status.replay_needed) |=> !req_if.ready)
      else $error("request taken right after a replay started");

   // a response without a packet always ends its transaction
   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && !rsp_if.packet_valid) |-> rsp_if.last)
      else $error("packetless response not marked last");

   // an accepted send always carries its packet
   a_accept_has_packet: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.send_accepted) |-> rsp_if.packet_valid)
      else $error("accepted send without packet");

   // no response right after reset
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_if.valid)
      else $error("response valid after reset");

endmodule
